### rtl/swtq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue package
// Shared types, field widths and codes for the timer queue and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package swtq_pkg;

  localparam int ID_W    = 8;
  localparam int SLEEP_W = 32;
  localparam int TIME_W  = 48;
  localparam int COUNT_W = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_POP      = 2'd2,
    OP_PEEK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NOT_DUE = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_DROP,
    S_INS,
    S_RESP
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              carry;
    logic              zero;
    logic [TIME_W-1:0] value;
  } alu_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wake;
  } entry_t;

endpackage

`default_nettype wire

### rtl/swtq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/swtq_alu.sv
// ----------------------------------------------------------------------------
// Timer queue time unit
// Shared 48-bit adder and subtractor: saturating add for wakeup times,
// subtract with borrow and zero flag for time compares and tick counts.
// ----------------------------------------------------------------------------
`default_nettype none

module swtq_alu (
  input  wire swtq_pkg::alu_req_t req,
  output swtq_pkg::alu_rsp_t      rsp
);

  logic [swtq_pkg::TIME_W:0] sum;

  always_comb begin
    if (req.op == swtq_pkg::ALU_ADD) begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end
    rsp.carry = sum[swtq_pkg::TIME_W];
    if (req.op == swtq_pkg::ALU_ADD && sum[swtq_pkg::TIME_W]) begin
      rsp.value = swtq_pkg::TIME_MAX;
    end else begin
      rsp.value = sum[swtq_pkg::TIME_W-1:0];
    end
    rsp.zero = (rsp.value == '0);
  end

endmodule

`default_nettype wire

### rtl/sorted_wakeup_timer_queue.sv
// Pop or peek on an empty queue answers without reading the entries; peek or a pop reads the head first.
// Schedule and remove pass over every held entry to drop a matching id, and a due pop drops the head.
// Schedule then shifts later entries up, one at a time, to insert the new entry in wakeup order.
// One item is in work at a time; every entry step goes through the single entry memory.
// A finished result waits in the output register while the next item is accepted.
// Reset empties the queue at once; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue
// Keeps task ids ordered by wakeup time in one entry memory. A sequencer
// compacts, shifts and inserts entries one per cycle using a shared time unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_wakeup_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [swtq_pkg::ID_W-1:0]     in_task_id,
  input  wire logic [swtq_pkg::SLEEP_W-1:0]  in_sleep_ticks,
  input  wire logic [swtq_pkg::TIME_W-1:0]   in_now,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [swtq_pkg::ID_W-1:0]          out_next_task_id,
  output logic [swtq_pkg::TIME_W-1:0]        out_wait_ticks,
  output logic [1:0]                         out_status,
  output logic [swtq_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = $bits(swtq_pkg::entry_t);

  swtq_pkg::state_t  state_r, state_nxt;
  swtq_pkg::op_t     op_r, op_nxt;
  logic [swtq_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [swtq_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [swtq_pkg::TIME_W-1:0] wake_r, wake_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     w_r, w_nxt;
  logic              vld_r, vld_nxt;
  logic              hit_r, hit_nxt;
  logic              popm_r, popm_nxt;

  logic                        res_found_r, res_found_nxt;
  logic [swtq_pkg::ID_W-1:0]   res_id_r, res_id_nxt;
  logic [swtq_pkg::TIME_W-1:0] res_wait_r, res_wait_nxt;
  swtq_pkg::status_t           res_status_r, res_status_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [swtq_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic [swtq_pkg::TIME_W-1:0]  out_wait_r, out_wait_nxt;
  swtq_pkg::status_t            out_status_r, out_status_nxt;
  logic [swtq_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  swtq_pkg::alu_req_t alu_req;
  swtq_pkg::alu_rsp_t alu_rsp;

  logic               wr_en;
  logic [CW-1:0]      wr_idx;
  swtq_pkg::entry_t   wr_entry;
  logic [CW-1:0]      rd_idx;
  logic [ENTRY_W-1:0] rd_data;
  swtq_pkg::entry_t   rd_entry;
  swtq_pkg::entry_t   new_entry;
  logic               skip;

  assign rd_entry  = swtq_pkg::entry_t'(rd_data);
  assign new_entry = '{id: id_r, wake: wake_r};

  swtq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_entries (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_idx[AW-1:0]),
    .wr_data(wr_entry),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  swtq_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swtq_pkg::S_IDLE;
      occ_r       <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    now_r        <= now_nxt;
    wake_r       <= wake_nxt;
    idx_r        <= idx_nxt;
    w_r          <= w_nxt;
    hit_r        <= hit_nxt;
    popm_r       <= popm_nxt;
    res_found_r  <= res_found_nxt;
    res_id_r     <= res_id_nxt;
    res_wait_r   <= res_wait_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_id_r     <= out_id_nxt;
    out_wait_r   <= out_wait_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    now_nxt        = now_r;
    wake_nxt       = wake_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    w_nxt          = w_r;
    vld_nxt        = vld_r;
    hit_nxt        = hit_r;
    popm_nxt       = popm_r;
    res_found_nxt  = res_found_r;
    res_id_nxt     = res_id_r;
    res_wait_nxt   = res_wait_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_id_nxt     = out_id_r;
    out_wait_nxt   = out_wait_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    in_ready       = (state_r == swtq_pkg::S_IDLE);
    wr_en          = 1'b0;
    wr_idx         = w_r;
    wr_entry       = rd_entry;
    rd_idx         = '0;
    skip           = 1'b0;
    alu_req.op     = swtq_pkg::ALU_ADD;
    alu_req.a      = in_now;
    alu_req.b      = swtq_pkg::TIME_W'(in_sleep_ticks);

    case (state_r)
      swtq_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt         = swtq_pkg::op_t'(in_operation);
          id_nxt         = in_task_id;
          now_nxt        = in_now;
          wake_nxt       = alu_rsp.value;
          res_found_nxt  = 1'b0;
          res_id_nxt     = '0;
          res_wait_nxt   = '0;
          res_status_nxt = swtq_pkg::STAT_OK;
          idx_nxt        = '0;
          w_nxt          = '0;
          vld_nxt        = 1'b0;
          hit_nxt        = 1'b0;
          popm_nxt       = 1'b0;
          case (swtq_pkg::op_t'(in_operation))
            swtq_pkg::OP_SCHEDULE, swtq_pkg::OP_REMOVE: begin
              state_nxt = swtq_pkg::S_DROP;
            end
            default: begin
              if (occ_r == '0) begin
                res_status_nxt = swtq_pkg::STAT_EMPTY;
                state_nxt      = swtq_pkg::S_RESP;
              end else begin
                state_nxt = swtq_pkg::S_HEAD;
              end
            end
          endcase
        end
      end

      swtq_pkg::S_HEAD: begin
        alu_req.op = swtq_pkg::ALU_SUB;
        alu_req.a  = rd_entry.wake;
        alu_req.b  = now_r;
        res_id_nxt = rd_entry.id;
        if (!alu_rsp.carry && !alu_rsp.zero) begin
          res_wait_nxt   = alu_rsp.value;
          res_status_nxt = swtq_pkg::STAT_NOT_DUE;
          res_found_nxt  = (op_r == swtq_pkg::OP_PEEK);
          state_nxt      = swtq_pkg::S_RESP;
        end else begin
          res_found_nxt = 1'b1;
          if (op_r == swtq_pkg::OP_POP) begin
            popm_nxt  = 1'b1;
            state_nxt = swtq_pkg::S_DROP;
          end else begin
            state_nxt = swtq_pkg::S_RESP;
          end
        end
      end

      swtq_pkg::S_DROP: begin
        if (vld_r) begin
          skip = popm_r ? (idx_r == CW'(1)) : (rd_entry.id == id_r);
          if (skip) begin
            hit_nxt = 1'b1;
          end else begin
            wr_en  = 1'b1;
            wr_idx = w_r;
            w_nxt  = w_r + CW'(1);
          end
        end
        if (idx_r < occ_r) begin
          rd_idx  = idx_r;
          idx_nxt = idx_r + CW'(1);
          vld_nxt = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
        if (!vld_r && !(idx_r < occ_r)) begin
          occ_nxt = w_r;
          case (op_r)
            swtq_pkg::OP_SCHEDULE: begin
              idx_nxt = w_r;
              if (w_r == CW'(QUEUE_DEPTH)) begin
                res_status_nxt = swtq_pkg::STAT_FULL;
                state_nxt      = swtq_pkg::S_RESP;
              end else begin
                state_nxt = swtq_pkg::S_INS;
              end
            end
            swtq_pkg::OP_REMOVE: begin
              res_found_nxt = hit_r;
              state_nxt     = swtq_pkg::S_RESP;
            end
            default: begin
              state_nxt = swtq_pkg::S_RESP;
            end
          endcase
        end
      end

      swtq_pkg::S_INS: begin
        alu_req.op = swtq_pkg::ALU_SUB;
        alu_req.a  = rd_entry.wake;
        alu_req.b  = wake_r;
        if (vld_r) begin
          wr_en  = 1'b1;
          wr_idx = idx_r + CW'(1);
          if (!alu_rsp.carry) begin
            wr_entry = rd_entry;
            if (idx_r != '0) begin
              rd_idx  = idx_r - CW'(1);
              idx_nxt = idx_r - CW'(1);
              vld_nxt = 1'b1;
            end else begin
              vld_nxt = 1'b0;
            end
          end else begin
            wr_entry  = new_entry;
            vld_nxt   = 1'b0;
            occ_nxt   = occ_r + CW'(1);
            state_nxt = swtq_pkg::S_RESP;
          end
        end else if (idx_r != '0) begin
          rd_idx  = idx_r - CW'(1);
          idx_nxt = idx_r - CW'(1);
          vld_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = '0;
          wr_entry  = new_entry;
          occ_nxt   = occ_r + CW'(1);
          state_nxt = swtq_pkg::S_RESP;
        end
      end

      swtq_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_id_nxt     = res_id_r;
          out_wait_nxt   = res_wait_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = swtq_pkg::COUNT_W'(occ_r);
          state_nxt      = swtq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = swtq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_next_task_id = out_id_r;
  assign out_wait_ticks   = out_wait_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy exceeds its depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swtq_pkg::S_DROP) |-> (w_r <= idx_r))
    else $error("compaction write index passed the read index");

  a_occ_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != swtq_pkg::S_DROP && state_r != swtq_pkg::S_INS) |=> $stable(occ_r))
    else $error("occupancy changed outside an entry pass");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swtq_pkg::S_INS) |-> (occ_r < CW'(QUEUE_DEPTH)))
    else $error("insert pass started on a full queue");
`endif

endmodule

`default_nettype wire
